// File: hw/rtl/rvk_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rvk_pkg
// Shared types and constants for the rotary encoder volume knob.
// ---------------------------------------------------------------------------
`default_nettype none

package rvk_pkg;

	localparam int CountW  = 16;
	localparam int VolW    = 7;
	localparam int ModeW   = 2;
	localparam int AddrW   = 4;
	localparam int DataW   = 32;

	localparam logic [CountW-1:0] SettleTicksRst = 16'd3;
	localparam logic [CountW-1:0] BtnTicksRst    = 16'd300;
	localparam logic [VolW-1:0]   VolMaxRst      = 7'd100;
	localparam logic [VolW-1:0]   PositionRst    = 7'd50;

	// event kinds
	typedef enum logic [ModeW-1:0] {
		MODE_TICK     = 2'd0,
		MODE_CLK_EDGE = 2'd1,
		MODE_BTN_EDGE = 2'd2
	} mode_t;

	// register index (paddr[3:2])
	typedef enum logic [1:0] {
		REG_SETTLE_TICKS = 2'd0,
		REG_BTN_TICKS    = 2'd1,
		REG_VOLUME_MAX   = 2'd2
	} reg_idx_t;

endpackage

`default_nettype wire

// File: hw/rtl/rotary_encoder_volume_knob.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotary_encoder_volume_knob
// Debounced rotary encoder turned into a saturating volume value.
// ---------------------------------------------------------------------------
// Usage:
//   Event channel (evt_valid / evt_stall): one item per timer tick, encoder
//   clock falling edge (with the data line level) or button falling edge.
//   Result channel (res_valid / res_stall): exactly one item per event,
//   carrying the current volume, a volume_changed flag and a stop_request.
//   Config: APB-style, settle_ticks at 0x0, button_lockout_ticks at 0x4,
//   volume_max at 0x8. pready is tied high; reads return register values.
// Timing:
//   Two register stages: event register (_s1) then result register (_s2).
//   The event register passes its item on to the result register whenever
//   res_stall is low or the result slot is empty, sustaining one item per
//   cycle. The whole state update for an item is a single pass of small
//   counter and compare logic between the two registers.
// Stall:
//   When res_stall is high and a result is held, the result register holds,
//   the event register still takes one item if it is empty, and evt_stall
//   rises once the event register is occupied. No item is lost.
// Reset:
//   arst_n clears valid bits, lockout counters, phase and direction, sets
//   position to 50 and the registers to 3 / 300 / 100.
// ---------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_volume_knob (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// event channel
	input  wire logic                     evt_valid,
	output logic                          evt_stall,
	input  wire logic [rvk_pkg::ModeW-1:0] mode,
	input  wire logic                     data_line_level,
	// result channel
	output logic                          res_valid,
	input  wire logic                     res_stall,
	output logic [rvk_pkg::VolW-1:0]      volume,
	output logic                          volume_changed,
	output logic                          stop_request,
	// configuration
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [rvk_pkg::AddrW-1:0] paddr,
	input  wire logic [rvk_pkg::DataW-1:0] pwdata,
	output logic [rvk_pkg::DataW-1:0]     prdata,
	output logic                          pready
);

	localparam int CW = rvk_pkg::CountW;
	localparam int VW = rvk_pkg::VolW;

	// configuration registers
	logic [CW-1:0] settle_ticks_q;
	logic [CW-1:0] btn_ticks_q;
	logic [VW-1:0] volume_max_q;

	// knob state
	logic [CW-1:0] settle_count_q;
	logic [CW-1:0] button_count_q;
	logic          step_up_q;
	logic          phase_q;
	logic [VW-1:0] position_q;

	// pipeline
	logic                      valid_s1;
	logic [rvk_pkg::ModeW-1:0] mode_s1;
	logic                      data_s1;
	logic                      valid_s2;

	logic adv;
	logic load_s1;
	logic cfg_wr;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	// result slot free or draining: stage 1 moves on into stage 2
	assign adv       = ~valid_s2 | ~res_stall;
	// event register loads when it empties or is already empty
	assign load_s1   = adv | ~valid_s1;
	assign evt_stall = ~load_s1;
	assign res_valid = valid_s2;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			rvk_pkg::REG_SETTLE_TICKS: prdata = {{(rvk_pkg::DataW-CW){1'b0}}, settle_ticks_q};
			rvk_pkg::REG_BTN_TICKS:    prdata = {{(rvk_pkg::DataW-CW){1'b0}}, btn_ticks_q};
			rvk_pkg::REG_VOLUME_MAX:   prdata = {{(rvk_pkg::DataW-VW){1'b0}}, volume_max_q};
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ticks_q <= rvk_pkg::SettleTicksRst;
			btn_ticks_q    <= rvk_pkg::BtnTicksRst;
			volume_max_q   <= rvk_pkg::VolMaxRst;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				rvk_pkg::REG_SETTLE_TICKS: settle_ticks_q <= pwdata[CW-1:0];
				rvk_pkg::REG_BTN_TICKS:    btn_ticks_q    <= pwdata[CW-1:0];
				rvk_pkg::REG_VOLUME_MAX:   volume_max_q   <= pwdata[VW-1:0];
				default: ;
			endcase
		end
	end

	// -------------------------------------------------------------------
	// Stage 1: event register
	// -------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && evt_valid) begin
			mode_s1 <= mode;
			data_s1 <= data_line_level;
		end
	end

	// -------------------------------------------------------------------
	// Stage 2 logic: state update for the registered event
	// -------------------------------------------------------------------
	logic [CW-1:0] settle_count_d;
	logic [CW-1:0] button_count_d;
	logic          step_up_d;
	logic          phase_d;
	logic [VW-1:0] position_d;
	logic [VW-1:0] pos_step;
	logic          settle_done;
	logic          changed_d;
	logic          stop_d;
	logic [VW-1:0] volume_d;

	always_comb begin
		settle_count_d = settle_count_q;
		button_count_d = button_count_q;
		step_up_d      = step_up_q;
		phase_d        = phase_q;
		position_d     = position_q;
		settle_done    = 1'b0;
		changed_d      = 1'b0;
		stop_d         = 1'b0;
		pos_step       = position_q;

		unique case (mode_s1)
			rvk_pkg::MODE_TICK: begin
				// encoder lockout: compare old value, then advance (wraps silently)
				if (settle_count_q != '0) begin
					if (settle_count_q > settle_ticks_q) begin
						settle_count_d = '0;
						settle_done    = 1'b1;
					end else begin
						settle_count_d = settle_count_q + CW'(1);
					end
				end
				if (settle_done) begin
					phase_d = ~phase_q;
					if (!phase_q) begin
						if (step_up_q) begin
							if (position_q < volume_max_q)
								pos_step = position_q + VW'(1);
						end else begin
							if (position_q != '0)
								pos_step = position_q - VW'(1);
						end
						position_d = (pos_step > volume_max_q) ? volume_max_q : pos_step;
						changed_d  = 1'b1;
					end
				end
				// button lockout
				if (button_count_q != '0) begin
					if (button_count_q > btn_ticks_q)
						button_count_d = '0;
					else
						button_count_d = button_count_q + CW'(1);
				end
			end
			rvk_pkg::MODE_CLK_EDGE: begin
				if (settle_count_q == '0) begin
					step_up_d      = data_s1;
					settle_count_d = CW'(1);
				end
			end
			rvk_pkg::MODE_BTN_EDGE: begin
				if (button_count_q == '0) begin
					button_count_d = CW'(1);
					stop_d         = 1'b1;
				end
			end
			default: ;
		endcase

		volume_d = (position_d > volume_max_q) ? '0 : (volume_max_q - position_d);
	end

	logic take;
	assign take = adv & valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_count_q <= '0;
			button_count_q <= '0;
			step_up_q      <= 1'b0;
			phase_q        <= 1'b0;
			position_q     <= rvk_pkg::PositionRst;
			valid_s2       <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (take) begin
				settle_count_q <= settle_count_d;
				button_count_q <= button_count_d;
				step_up_q      <= step_up_d;
				phase_q        <= phase_d;
				position_q     <= position_d;
			end
		end
	end

	// -------------------------------------------------------------------
	// Stage 2: result register
	// -------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (take) begin
			volume         <= volume_d;
			volume_changed <= changed_d;
			stop_request   <= stop_d;
		end
	end

endmodule

`default_nettype wire
